// ===== rtl/single_wire_sensor_frame_decoder_top_macros.svh =====
// assertion macros for the single-wire sensor frame decoder
// used by the checker; expects clk_i and rst_ni in scope
`ifndef SINGLE_WIRE_SENSOR_FRAME_DECODER_TOP_MACROS_SVH
`define SINGLE_WIRE_SENSOR_FRAME_DECODER_TOP_MACROS_SVH

// checked outside reset
`define SWSFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define SWSFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/swsfd_pkg.sv =====
// shared types and constants of the single-wire sensor frame decoder
// no dependencies
`default_nettype none

package swsfd_pkg;

  localparam int FRAME_BITS = 40;
  localparam int FRAME_W    = 40;
  localparam int CNT_W      = $clog2(FRAME_BITS + 1);
  localparam int IVL_W      = 10;
  localparam int BYTE_W     = 8;
  localparam int READ_W     = 4 * BYTE_W;
  localparam int MILLI_W    = 18;
  localparam int CFG_IDX_W  = 2;

  localparam logic [IVL_W-1:0] ONE_MIN_RST  = IVL_W'(110);
  localparam logic [IVL_W-1:0] ONE_MAX_RST  = IVL_W'(130);
  localparam logic [IVL_W-1:0] ZERO_MIN_RST = IVL_W'(65);
  localparam logic [IVL_W-1:0] ZERO_MAX_RST = IVL_W'(90);
  localparam logic [MILLI_W-1:0] MILLI_SCALE = MILLI_W'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ONE_MIN  = 2'd0,
    CFG_ONE_MAX  = 2'd1,
    CFG_ZERO_MIN = 2'd2,
    CFG_ZERO_MAX = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_EDGE    = 2'd1,
    OP_TIMEOUT = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_NEW      = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_ERROR    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_PRE0 = 3'd1,
    PH_PRE1 = 3'd2,
    PH_DATA = 3'd3,
    PH_DONE = 3'd4,
    PH_ERR  = 3'd5
  } phase_e;

  typedef struct packed {
    logic [IVL_W-1:0] one_min;
    logic [IVL_W-1:0] one_max;
    logic [IVL_W-1:0] zero_min;
    logic [IVL_W-1:0] zero_max;
  } cfg_t;

  typedef struct packed {
    status_e           status;
    logic [READ_W-1:0] readings;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/swsfd_cfg.sv =====
// interval window registers with plain write port
// depends on swsfd_pkg
`default_nettype none

module swsfd_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [swsfd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [swsfd_pkg::IVL_W-1:0]     cfg_wdata_i,
  output swsfd_pkg::cfg_t                      cfg_o
);

  swsfd_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (swsfd_pkg::cfg_idx_e'(cfg_index_i))
        swsfd_pkg::CFG_ONE_MIN:  cfg_d.one_min  = cfg_wdata_i;
        swsfd_pkg::CFG_ONE_MAX:  cfg_d.one_max  = cfg_wdata_i;
        swsfd_pkg::CFG_ZERO_MIN: cfg_d.zero_min = cfg_wdata_i;
        swsfd_pkg::CFG_ZERO_MAX: cfg_d.zero_max = cfg_wdata_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.one_min  <= swsfd_pkg::ONE_MIN_RST;
      cfg_q.one_max  <= swsfd_pkg::ONE_MAX_RST;
      cfg_q.zero_min <= swsfd_pkg::ZERO_MIN_RST;
      cfg_q.zero_max <= swsfd_pkg::ZERO_MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/swsfd_core.sv =====
// input register, measurement state machine, bit decode and checksum
// depends on swsfd_pkg
`default_nettype none

module swsfd_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  op_i,
  input  wire logic [swsfd_pkg::IVL_W-1:0] interval_us_i,
  input  swsfd_pkg::cfg_t                  cfg_i,
  output logic                             res_valid_o,
  output swsfd_pkg::res_t                  res_o,
  input  wire logic                        res_ready_i
);

  localparam int FW = swsfd_pkg::FRAME_W;
  localparam int BW = swsfd_pkg::BYTE_W;

  logic                          in_valid_q;
  logic [1:0]                    op_q;
  logic [swsfd_pkg::IVL_W-1:0]   ivl_q;

  swsfd_pkg::phase_e             phase_q, phase_d;
  logic [swsfd_pkg::CNT_W-1:0]   bit_cnt_q, bit_cnt_d, cnt_inc;
  logic [FW-1:0]                 frame_q, frame_d, frame_sh;
  logic [swsfd_pkg::READ_W-1:0]  held_q, held_d;
  logic                          held_vld_q, held_vld_d;

  logic       is_one, is_zero, bad, emit, advance;
  logic [BW-1:0] csum;

  assign is_one  = (ivl_q > cfg_i.one_min) && (ivl_q < cfg_i.one_max);
  assign is_zero = (ivl_q > cfg_i.zero_min) && (ivl_q < cfg_i.zero_max);
  assign bad     = !is_one && !is_zero;
  assign frame_sh = {frame_q[FW-2:0], is_one};
  assign cnt_inc  = bit_cnt_q + swsfd_pkg::CNT_W'(1);
  assign csum = frame_sh[2*BW-1:BW] + frame_sh[3*BW-1:2*BW]
              + frame_sh[4*BW-1:3*BW] + frame_sh[5*BW-1:4*BW];

  always_comb begin
    phase_d    = phase_q;
    bit_cnt_d  = bit_cnt_q;
    frame_d    = frame_q;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    emit       = 1'b0;
    res_o.status   = swsfd_pkg::ST_ERROR;
    res_o.readings = '0;
    case (swsfd_pkg::op_e'(op_q))
      swsfd_pkg::OP_START: begin
        phase_d   = swsfd_pkg::PH_PRE0;
        bit_cnt_d = '0;
        frame_d   = '0;
      end
      swsfd_pkg::OP_TIMEOUT: begin
        if (phase_q inside {swsfd_pkg::PH_PRE0, swsfd_pkg::PH_PRE1,
                            swsfd_pkg::PH_DATA, swsfd_pkg::PH_ERR}) begin
          emit       = 1'b1;
          phase_d    = swsfd_pkg::PH_DONE;
          held_d     = '0;
          held_vld_d = 1'b0;
        end
      end
      swsfd_pkg::OP_EDGE: begin
        case (phase_q)
          swsfd_pkg::PH_PRE0: begin
            bit_cnt_d = '0;
            phase_d   = swsfd_pkg::PH_PRE1;
          end
          swsfd_pkg::PH_PRE1: phase_d = swsfd_pkg::PH_DATA;
          swsfd_pkg::PH_DATA: begin
            frame_d   = frame_sh;
            bit_cnt_d = cnt_inc;
            if (cnt_inc == swsfd_pkg::CNT_W'(swsfd_pkg::FRAME_BITS)) begin
              emit    = 1'b1;
              phase_d = swsfd_pkg::PH_DONE;
              if (bad) begin
                held_d     = '0;
                held_vld_d = 1'b0;
              end else if (csum == frame_sh[BW-1:0]) begin
                held_d         = frame_sh[5*BW-1:BW];
                held_vld_d     = 1'b1;
                res_o.status   = swsfd_pkg::ST_NEW;
                res_o.readings = frame_sh[5*BW-1:BW];
              end else begin
                res_o.status   = swsfd_pkg::ST_MISMATCH;
                res_o.readings = held_vld_q ? held_q : '0;
              end
            end else if (bad) begin
              phase_d = swsfd_pkg::PH_ERR;
            end
          end
          default: phase_d = phase_q;
        endcase
      end
      default: phase_d = phase_q;
    endcase
  end

  assign advance     = in_valid_q && (!emit || res_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign res_valid_o = in_valid_q && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      phase_q    <= swsfd_pkg::PH_IDLE;
      bit_cnt_q  <= '0;
      frame_q    <= '0;
      held_q     <= '0;
      held_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        phase_q    <= phase_d;
        bit_cnt_q  <= bit_cnt_d;
        frame_q    <= frame_d;
        held_q     <= held_d;
        held_vld_q <= held_vld_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q  <= op_i;
      ivl_q <= interval_us_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/swsfd_out.sv =====
// result register with reading split and milli scaling
// depends on swsfd_pkg
`default_nettype none

module swsfd_out (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          res_valid_i,
  output logic                               res_ready_o,
  input  swsfd_pkg::res_t                    res_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         status_o,
  output logic [swsfd_pkg::BYTE_W-1:0]       humidity_whole_o,
  output logic [swsfd_pkg::BYTE_W-1:0]       humidity_fraction_o,
  output logic [swsfd_pkg::BYTE_W-1:0]       temperature_whole_o,
  output logic [swsfd_pkg::BYTE_W-1:0]       temperature_fraction_o,
  output logic [swsfd_pkg::MILLI_W-1:0]      humidity_milli_o,
  output logic [swsfd_pkg::MILLI_W-1:0]      temperature_milli_o
);

  localparam int BW = swsfd_pkg::BYTE_W;
  localparam int MW = swsfd_pkg::MILLI_W;

  logic           out_valid_q;
  swsfd_pkg::res_t res_q;
  logic [MW-1:0]  hum_milli_q, hum_milli_d, tmp_milli_q, tmp_milli_d;
  logic           load;

  assign res_ready_o = !out_valid_q || out_ready_i;
  assign load        = res_valid_i && res_ready_o;

  assign hum_milli_d = MW'(res_i.readings[4*BW-1:3*BW]) * swsfd_pkg::MILLI_SCALE
                     + MW'(res_i.readings[3*BW-1:2*BW]);
  assign tmp_milli_d = MW'(res_i.readings[2*BW-1:BW]) * swsfd_pkg::MILLI_SCALE
                     + MW'(res_i.readings[BW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready_o) begin
      out_valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q       <= res_i;
      hum_milli_q <= hum_milli_d;
      tmp_milli_q <= tmp_milli_d;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign status_o               = res_q.status;
  assign humidity_whole_o       = res_q.readings[4*BW-1:3*BW];
  assign humidity_fraction_o    = res_q.readings[3*BW-1:2*BW];
  assign temperature_whole_o    = res_q.readings[2*BW-1:BW];
  assign temperature_fraction_o = res_q.readings[BW-1:0];
  assign humidity_milli_o       = hum_milli_q;
  assign temperature_milli_o    = tmp_milli_q;

endmodule

`default_nettype wire

// ===== rtl/single_wire_sensor_frame_decoder_top.sv =====
// top level of the single-wire sensor frame decoder
// depends on swsfd_pkg, swsfd_cfg, swsfd_core, swsfd_out
//
//   channel   handshake                 payload
//   in        in_valid_i / in_ready_o   op_i, interval_us_i
//   out       out_valid_o / out_ready_i status_o, readings, milli values
//   cfg       cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// one request per cycle unless a result is stalled at the output
// path: input register, window compare and checksum, result register
// reset clears state, held readings and both valid flags; windows return to defaults
// while a result waits, a request that makes a result is held in the input register
`default_nettype none

module single_wire_sensor_frame_decoder_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [1:0]                      op_i,
  input  wire logic [swsfd_pkg::IVL_W-1:0]     interval_us_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [1:0]                           status_o,
  output logic [swsfd_pkg::BYTE_W-1:0]         humidity_whole_o,
  output logic [swsfd_pkg::BYTE_W-1:0]         humidity_fraction_o,
  output logic [swsfd_pkg::BYTE_W-1:0]         temperature_whole_o,
  output logic [swsfd_pkg::BYTE_W-1:0]         temperature_fraction_o,
  output logic [swsfd_pkg::MILLI_W-1:0]        humidity_milli_o,
  output logic [swsfd_pkg::MILLI_W-1:0]        temperature_milli_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [swsfd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [swsfd_pkg::IVL_W-1:0]     cfg_wdata_i
);

  swsfd_pkg::cfg_t cfg;
  swsfd_pkg::res_t res;
  logic            res_valid, res_ready;

  swsfd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  swsfd_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .interval_us_i (interval_us_i),
    .cfg_i         (cfg),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_ready_i   (res_ready)
  );

  swsfd_out u_out (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .res_valid_i            (res_valid),
    .res_ready_o            (res_ready),
    .res_i                  (res),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .status_o               (status_o),
    .humidity_whole_o       (humidity_whole_o),
    .humidity_fraction_o    (humidity_fraction_o),
    .temperature_whole_o    (temperature_whole_o),
    .temperature_fraction_o (temperature_fraction_o),
    .humidity_milli_o       (humidity_milli_o),
    .temperature_milli_o    (temperature_milli_o)
  );

endmodule

`default_nettype wire

// ===== rtl/swsfd_chk.sv =====
// port-level checker for the single-wire sensor frame decoder, bound to the top
// depends on swsfd_pkg and single_wire_sensor_frame_decoder_top_macros.svh
`default_nettype none
`include "single_wire_sensor_frame_decoder_top_macros.svh"

module swsfd_chk (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_ready_o,
  input wire logic [1:0]                      op_i,
  input wire logic [swsfd_pkg::IVL_W-1:0]     interval_us_i,
  input wire logic                            out_valid_o,
  input wire logic                            out_ready_i,
  input wire logic [1:0]                      status_o,
  input wire logic [swsfd_pkg::BYTE_W-1:0]    humidity_whole_o,
  input wire logic [swsfd_pkg::BYTE_W-1:0]    humidity_fraction_o,
  input wire logic [swsfd_pkg::BYTE_W-1:0]    temperature_whole_o,
  input wire logic [swsfd_pkg::BYTE_W-1:0]    temperature_fraction_o,
  input wire logic [swsfd_pkg::MILLI_W-1:0]   humidity_milli_o,
  input wire logic [swsfd_pkg::MILLI_W-1:0]   temperature_milli_o,
  input wire logic                            cfg_we_i,
  input wire logic [swsfd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input wire logic [swsfd_pkg::IVL_W-1:0]     cfg_wdata_i
);

  localparam int MW = swsfd_pkg::MILLI_W;

  `SWSFD_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !out_valid_o,
    "result valid during reset")

  `SWSFD_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(humidity_milli_o) && $stable(temperature_milli_o),
    "stalled result changed")

  `SWSFD_ASSERT(a_milli, out_valid_o |-> humidity_milli_o == MW'(humidity_whole_o) * MW'(1000) + MW'(humidity_fraction_o) && temperature_milli_o == MW'(temperature_whole_o) * MW'(1000) + MW'(temperature_fraction_o),
    "milli value does not match reading bytes")

  `SWSFD_ASSERT(a_err_zero, out_valid_o && status_o == swsfd_pkg::ST_ERROR |-> humidity_whole_o == '0 && humidity_fraction_o == '0 && temperature_whole_o == '0 && temperature_fraction_o == '0,
    "error result carries readings")

  `SWSFD_ASSERT(a_status_code, out_valid_o |-> status_o == swsfd_pkg::ST_NEW || status_o == swsfd_pkg::ST_MISMATCH || status_o == swsfd_pkg::ST_ERROR,
    "undefined status code")

endmodule

bind single_wire_sensor_frame_decoder_top swsfd_chk u_swsfd_chk (.*);

`default_nettype wire
